[design/jjy_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package jjy_pkg;

    // Width of the tick counter inside one second.
    localparam int TICK_COUNT_BITS = 12;
    localparam int CFG_W = 12;
    localparam int CFG_ADDR_W = 2;
    // Compare width: wide enough for counter and registers plus one carry bit.
    localparam int CMP_W = ((TICK_COUNT_BITS > CFG_W) ? TICK_COUNT_BITS : CFG_W) + 1;

    localparam int FRAME_LEN = 60;
    localparam int SEC_W = 6;
    localparam logic [SEC_W-1:0] LAST_SECOND = SEC_W'(FRAME_LEN - 1);

    localparam logic [CFG_W-1:0] TPS_RESET = CFG_W'(1000);
    localparam logic [CFG_W-1:0] MARKER_RESET = CFG_W'(200);
    localparam logic [CFG_W-1:0] ONE_RESET = CFG_W'(500);
    localparam logic [CFG_W-1:0] ZERO_RESET = CFG_W'(800);

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_TICKS_PER_SECOND = 2'd0,
        REG_MARKER_LOW = 2'd1,
        REG_ONE_LOW = 2'd2,
        REG_ZERO_LOW = 2'd3
    } cfg_reg_t;

    typedef enum logic [1:0] {
        SYM_ZERO = 2'd0,
        SYM_ONE = 2'd1,
        SYM_MARK = 2'd2
    } sym_t;

    typedef struct packed {
        logic load;
        logic shift;
    } cell_ctrl_t;

endpackage

`default_nettype wire

[design/jjy_cell.sv]
`timescale 1ns / 1ps
`default_nettype none

module jjy_cell (
    input  wire                 aclk,
    input  jjy_pkg::cell_ctrl_t ctrl,
    input  jjy_pkg::sym_t       load_sym,
    input  jjy_pkg::sym_t       right_sym,
    output jjy_pkg::sym_t       sym
);

    jjy_pkg::sym_t sym_reg;
    jjy_pkg::sym_t sym_next;

    always_comb begin
        sym_next = sym_reg;
        if (ctrl.load) begin
            sym_next = load_sym;
        end else if (ctrl.shift) begin
            sym_next = right_sym;
        end
    end

    always_ff @(posedge aclk) begin
        sym_reg <= sym_next;
    end

    assign sym = sym_reg;

endmodule

`default_nettype wire

[design/jjy_enc.sv]
`timescale 1ns / 1ps
`default_nettype none

module jjy_enc (
    input  wire [5:0]    minute,
    input  wire [4:0]    hour,
    input  wire [8:0]    day_of_year,
    input  wire [6:0]    year_two_digit,
    input  wire [2:0]    weekday,
    output jjy_pkg::sym_t frame_syms [jjy_pkg::FRAME_LEN]
);

    // Quotient by ten through a reciprocal multiply; exact for all 9-bit values.
    function automatic logic [8:0] div10(input logic [8:0] x);
        logic [19:0] p;
        p = 20'(x) * 20'd205;
        return p[19:11];
    endfunction

    // Quotient by one hundred; exact for all 9-bit values.
    function automatic logic [8:0] div100(input logic [8:0] x);
        logic [20:0] p;
        p = 21'(x) * 21'd41;
        return p[20:12];
    endfunction

    function automatic logic is_marker(input int s);
        return (s == 0) || (s == jjy_pkg::FRAME_LEN - 1) || ((s % 10) == 9);
    endfunction

    logic [8:0] mi_t, mi_o, hr_t, hr_o, dy_h, dy_r, dy_t, dy_o, yr_t, yr_o;
    logic [jjy_pkg::FRAME_LEN-1:0] bits;

    always_comb begin
        mi_t = div10(9'(minute));
        mi_o = 9'(minute) - 9'(mi_t * 9'd10);
        hr_t = div10(9'(hour));
        hr_o = 9'(hour) - 9'(hr_t * 9'd10);
        dy_h = div100(day_of_year);
        dy_r = day_of_year - 9'(dy_h * 9'd100);
        dy_t = div10(dy_r);
        dy_o = dy_r - 9'(dy_t * 9'd10);
        yr_t = div10(9'(year_two_digit));
        yr_o = 9'(year_two_digit) - 9'(yr_t * 9'd10);
    end

    // Each digit goes most significant bit first into the frame.
    always_comb begin
        bits = '0;
        bits[3:1] = {mi_t[0], mi_t[1], mi_t[2]};
        bits[8:5] = {mi_o[0], mi_o[1], mi_o[2], mi_o[3]};
        bits[13:12] = {hr_t[0], hr_t[1]};
        bits[18:15] = {hr_o[0], hr_o[1], hr_o[2], hr_o[3]};
        bits[23:22] = {dy_h[0], dy_h[1]};
        bits[28:25] = {dy_t[0], dy_t[1], dy_t[2], dy_t[3]};
        bits[33:30] = {dy_o[0], dy_o[1], dy_o[2], dy_o[3]};
        bits[36] = ^bits[18:12];
        bits[37] = ^bits[8:1];
        bits[44:41] = {yr_t[0], yr_t[1], yr_t[2], yr_t[3]};
        bits[48:45] = {yr_o[0], yr_o[1], yr_o[2], yr_o[3]};
        bits[52:50] = {weekday[0], weekday[1], weekday[2]};
    end

    always_comb begin
        for (int s = 0; s < jjy_pkg::FRAME_LEN; s++) begin
            if (is_marker(s)) begin
                frame_syms[s] = jjy_pkg::SYM_MARK;
            end else if (bits[s]) begin
                frame_syms[s] = jjy_pkg::SYM_ONE;
            end else begin
                frame_syms[s] = jjy_pkg::SYM_ZERO;
            end
        end
    end

endmodule

`default_nettype wire

[design/jjy_time_code_transmitter.sv]
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake             Contents
// s_        in         s_valid / s_ready     command, minute, hour, day_of_year, year, weekday
// m_        out        m_valid / m_ready     pin_level, second_index, symbol, frame_end, busy, ack
// cfg_      in         cfg_we                cfg_addr selects the register, cfg_wdata the value
//
// A new request is taken in each cycle that the output register is empty or being
// drained. The result is registered and appears in the cycle after acceptance.
// The frame is held as a row of sixty symbol cells that shift by one at each second.
// Reset clears the control state and loads the register defaults.

module jjy_time_code_transmitter (
    input  wire                           aclk,
    input  wire                           aresetn,

    input  wire                           cfg_we,
    input  wire [jjy_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  wire [jjy_pkg::CFG_W-1:0]      cfg_wdata,

    input  wire                           s_valid,
    output logic                          s_ready,
    input  wire                           s_command,
    input  wire [5:0]                     s_minute,
    input  wire [4:0]                     s_hour,
    input  wire [8:0]                     s_day_of_year,
    input  wire [6:0]                     s_year_two_digit,
    input  wire [2:0]                     s_weekday,

    output logic                          m_valid,
    input  wire                           m_ready,
    output logic                          m_pin_level,
    output logic [5:0]                    m_second_index,
    output logic [1:0]                    m_symbol,
    output logic                          m_frame_end,
    output logic                          m_busy_res,
    output logic                          m_start_accepted
);

    localparam int TW = jjy_pkg::TICK_COUNT_BITS;
    localparam int CW = jjy_pkg::CMP_W;
    localparam int N = jjy_pkg::FRAME_LEN;
    localparam logic [TW-1:0] TICK_MAX = {TW{1'b1}};

    logic [jjy_pkg::CFG_W-1:0] tps_reg, marker_reg, one_reg, zero_reg;

    logic [TW-1:0] tick_reg, tick_next;
    logic [jjy_pkg::SEC_W-1:0] sec_reg, sec_next;
    logic sending_reg, sending_next;

    logic m_valid_reg, m_valid_next;
    logic pin_reg, fend_reg, busy_reg, acc_reg;
    logic [jjy_pkg::SEC_W-1:0] sec_out_reg;
    jjy_pkg::sym_t sym_out_reg;

    logic pin_next, fend_next, busy_next, acc_next;
    logic [jjy_pkg::SEC_W-1:0] sec_out_next;
    jjy_pkg::sym_t sym_out_next;

    logic take, start_ok, tick_act, sec_end, last_sec, pin_tick;
    logic [jjy_pkg::CFG_W-1:0] eff, low_sel, low_clamp;
    logic [CW-1:0] t_ext;

    jjy_pkg::sym_t enc_syms [N];
    jjy_pkg::sym_t cell_syms [N];
    jjy_pkg::cell_ctrl_t cell_ctrl;
    jjy_pkg::sym_t head_sym;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tps_reg <= jjy_pkg::TPS_RESET;
            marker_reg <= jjy_pkg::MARKER_RESET;
            one_reg <= jjy_pkg::ONE_RESET;
            zero_reg <= jjy_pkg::ZERO_RESET;
        end else if (cfg_we) begin
            case (jjy_pkg::cfg_reg_t'(cfg_addr))
                jjy_pkg::REG_TICKS_PER_SECOND: tps_reg <= cfg_wdata;
                jjy_pkg::REG_MARKER_LOW: marker_reg <= cfg_wdata;
                jjy_pkg::REG_ONE_LOW: one_reg <= cfg_wdata;
                jjy_pkg::REG_ZERO_LOW: zero_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    jjy_enc u_enc (
        .minute(s_minute),
        .hour(s_hour),
        .day_of_year(s_day_of_year),
        .year_two_digit(s_year_two_digit),
        .weekday(s_weekday),
        .frame_syms(enc_syms)
    );

    // Cell i holds the symbol of the second that is i seconds ahead.
    for (genvar i = 0; i < N; i++) begin : g_cell
        jjy_pkg::sym_t right_sym;
        if (i == N - 1) begin : g_tail
            assign right_sym = jjy_pkg::SYM_ZERO;
        end else begin : g_mid
            assign right_sym = cell_syms[i+1];
        end
        jjy_cell u_cell (
            .aclk(aclk),
            .ctrl(cell_ctrl),
            .load_sym(enc_syms[i]),
            .right_sym(right_sym),
            .sym(cell_syms[i])
        );
    end

    assign head_sym = cell_syms[0];

    assign s_ready = !m_valid_reg || m_ready;
    assign take = s_valid && s_ready;
    assign start_ok = s_command && !sending_reg;
    assign tick_act = !s_command && sending_reg;

    always_comb begin
        eff = (tps_reg == '0) ? jjy_pkg::CFG_W'(1) : tps_reg;
        case (head_sym)
            jjy_pkg::SYM_MARK: low_sel = marker_reg;
            jjy_pkg::SYM_ONE: low_sel = one_reg;
            default: low_sel = zero_reg;
        endcase
        low_clamp = (low_sel > eff) ? eff : low_sel;
        t_ext = CW'(tick_reg);
        pin_tick = !(t_ext < CW'(low_clamp));
        sec_end = ((t_ext + CW'(1)) >= CW'(eff)) || (tick_reg == TICK_MAX);
        last_sec = sec_reg >= jjy_pkg::LAST_SECOND;
    end

    // Frame sequencing.
    always_comb begin
        tick_next = tick_reg;
        sec_next = sec_reg;
        sending_next = sending_reg;
        cell_ctrl = '0;
        if (take) begin
            if (start_ok) begin
                cell_ctrl.load = 1'b1;
                tick_next = '0;
                sec_next = '0;
                sending_next = 1'b1;
            end else if (tick_act) begin
                if (sec_end) begin
                    tick_next = '0;
                    cell_ctrl.shift = 1'b1;
                    if (last_sec) begin
                        sec_next = '0;
                        sending_next = 1'b0;
                    end else begin
                        sec_next = sec_reg + jjy_pkg::SEC_W'(1);
                    end
                end else begin
                    tick_next = tick_reg + TW'(1);
                end
            end
        end
    end

    // Result of the request being taken.
    always_comb begin
        pin_next = tick_act ? pin_tick : 1'b1;
        fend_next = tick_act && sec_end && last_sec;
        busy_next = start_ok || sending_reg;
        acc_next = start_ok;
        if (start_ok) begin
            sec_out_next = '0;
            sym_out_next = jjy_pkg::SYM_MARK;
        end else if (sending_reg) begin
            sec_out_next = sec_reg;
            sym_out_next = head_sym;
        end else begin
            sec_out_next = '0;
            sym_out_next = jjy_pkg::SYM_ZERO;
        end
        m_valid_next = take ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tick_reg <= '0;
            sec_reg <= '0;
            sending_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            tick_reg <= tick_next;
            sec_reg <= sec_next;
            sending_reg <= sending_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            pin_reg <= pin_next;
            fend_reg <= fend_next;
            busy_reg <= busy_next;
            acc_reg <= acc_next;
            sec_out_reg <= sec_out_next;
            sym_out_reg <= sym_out_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_pin_level = pin_reg;
    assign m_second_index = sec_out_reg;
    assign m_symbol = sym_out_reg;
    assign m_frame_end = fend_reg;
    assign m_busy_res = busy_reg;
    assign m_start_accepted = acc_reg;

endmodule

`default_nettype wire

[dv/testbench.sv]
`timescale 1ns / 1ps

module testbench;

    localparam int CLK_HALF = 5;
    localparam int CYCLE_LIMIT = 600000;
    localparam int RANDOM_REQS = 300;
    localparam int HOLD_OFF_AFTER = 500;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int TICK_FULL = (1 << jjy_pkg::TICK_COUNT_BITS) - 1;

    typedef struct packed {
        logic       command;
        logic [5:0] minute;
        logic [4:0] hour;
        logic [8:0] day_of_year;
        logic [6:0] year_two_digit;
        logic [2:0] weekday;
    } jjy_req_t;

    typedef struct packed {
        logic          pin;
        logic [5:0]    sec;
        jjy_pkg::sym_t sym;
        logic          fend;
        logic          busy;
        logic          acc;
    } jjy_res_t;

    typedef enum logic {
        ROW_CFG,
        ROW_REQ
    } row_kind_t;

    typedef struct {
        row_kind_t                 kind;
        jjy_pkg::cfg_reg_t         sel;
        logic [jjy_pkg::CFG_W-1:0] value;
        int                        reps;
        jjy_req_t                  req;
        bit                        typed;
        jjy_res_t                  res;
    } stim_row_t;

    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_START = 1'b1;

    logic                           aclk = 1'b0;
    logic                           aresetn;
    logic                           cfg_we;
    logic [jjy_pkg::CFG_ADDR_W-1:0] cfg_addr;
    logic [jjy_pkg::CFG_W-1:0]      cfg_wdata;
    logic                           s_valid;
    logic                           s_ready;
    logic                           s_command;
    logic [5:0]                     s_minute;
    logic [4:0]                     s_hour;
    logic [8:0]                     s_day_of_year;
    logic [6:0]                     s_year_two_digit;
    logic [2:0]                     s_weekday;
    logic                           m_valid;
    logic                           m_ready;
    logic                           m_pin_level;
    logic [5:0]                     m_second_index;
    logic [1:0]                     m_symbol;
    logic                           m_frame_end;
    logic                           m_busy_res;
    logic                           m_start_accepted;

    jjy_time_code_transmitter uut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_we           (cfg_we),
        .cfg_addr         (cfg_addr),
        .cfg_wdata        (cfg_wdata),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_command        (s_command),
        .s_minute         (s_minute),
        .s_hour           (s_hour),
        .s_day_of_year    (s_day_of_year),
        .s_year_two_digit (s_year_two_digit),
        .s_weekday        (s_weekday),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_pin_level      (m_pin_level),
        .m_second_index   (m_second_index),
        .m_symbol         (m_symbol),
        .m_frame_end      (m_frame_end),
        .m_busy_res       (m_busy_res),
        .m_start_accepted (m_start_accepted)
    );

    always #CLK_HALF aclk = ~aclk;

    // Predictor state: registers and transmitter progress.
    logic [jjy_pkg::CFG_W-1:0] tps_reg;
    logic [jjy_pkg::CFG_W-1:0] marker_reg;
    logic [jjy_pkg::CFG_W-1:0] one_reg;
    logic [jjy_pkg::CFG_W-1:0] zero_reg;
    logic [59:0]               frame_bits;
    int                        sec_ctr;
    int                        tick_ctr;
    bit                        sending;

    jjy_res_t   expected_line[$];
    stim_row_t  dir_rows[$];
    int         n_errors = 0;
    int         n_results = 0;
    int         n_sent = 0;
    int         n_cfg_writes = 0;
    int         frames_started = 0;
    int         frames_done = 0;
    int         cycle_cnt = 0;
    bit         held_off = 1'b0;

    function automatic logic [59:0] put_msb_first(logic [59:0] f, int pos, int v, int n);
        for (int i = 0; i < n; i++) begin
            if ((v >> (n - 1 - i)) & 1)
                f[pos + i] = 1'b1;
        end
        return f;
    endfunction

    function automatic logic [59:0] encode_time_frame(jjy_req_t r);
        logic [59:0] f;
        int mi, hr, dy, yr;
        f = '0;
        mi = int'(r.minute);
        hr = int'(r.hour);
        dy = int'(r.day_of_year);
        yr = int'(r.year_two_digit);
        f = put_msb_first(f, 1, mi / 10, 3);
        f = put_msb_first(f, 5, mi % 10, 4);
        f = put_msb_first(f, 12, hr / 10, 2);
        f = put_msb_first(f, 15, hr % 10, 4);
        f = put_msb_first(f, 22, dy / 100, 2);
        f = put_msb_first(f, 25, (dy % 100) / 10, 4);
        f = put_msb_first(f, 30, dy % 10, 4);
        // Hour parity goes in first; the minute parity range does not include it.
        f = put_msb_first(f, 36, int'(^f[18:12]), 1);
        f = put_msb_first(f, 37, int'(^f[8:1]), 1);
        f = put_msb_first(f, 41, yr / 10, 4);
        f = put_msb_first(f, 45, yr % 10, 4);
        f = put_msb_first(f, 50, int'(r.weekday), 3);
        return f;
    endfunction

    function automatic jjy_pkg::sym_t symbol_for(int s);
        if (s > 59)
            return jjy_pkg::SYM_ZERO;
        if (s == 0 || s == 59 || s % 10 == 9)
            return jjy_pkg::SYM_MARK;
        return frame_bits[s] ? jjy_pkg::SYM_ONE : jjy_pkg::SYM_ZERO;
    endfunction

    function automatic jjy_res_t advance_jjy(jjy_req_t r);
        jjy_res_t o;
        int eff, t, low;
        o = '0;
        o.pin = 1'b1;
        o.sym = jjy_pkg::SYM_ZERO;
        if (r.command == CMD_START) begin
            if (!sending) begin
                frame_bits = encode_time_frame(r);
                sec_ctr = 0;
                tick_ctr = 0;
                sending = 1'b1;
                o.acc = 1'b1;
                frames_started++;
            end
            o.sec = 6'(sec_ctr);
            o.sym = symbol_for(sec_ctr);
            o.busy = 1'b1;
        end else if (sending) begin
            eff = (tps_reg == 0) ? 1 : int'(tps_reg);
            t = tick_ctr;
            o.sec = 6'(sec_ctr);
            o.sym = symbol_for(sec_ctr);
            case (o.sym)
                jjy_pkg::SYM_MARK: low = int'(marker_reg);
                jjy_pkg::SYM_ONE:  low = int'(one_reg);
                default:           low = int'(zero_reg);
            endcase
            if (low > eff)
                low = eff;
            o.pin = (t < low) ? 1'b0 : 1'b1;
            o.busy = 1'b1;
            if (t + 1 >= eff || t == TICK_FULL) begin
                tick_ctr = 0;
                if (sec_ctr >= 59) begin
                    o.fend = 1'b1;
                    sec_ctr = 0;
                    sending = 1'b0;
                    frames_done++;
                end else begin
                    sec_ctr++;
                end
            end else begin
                tick_ctr = t + 1;
            end
        end
        return o;
    endfunction

    function automatic jjy_req_t mk_req(logic cmd, int mi, int hr, int dy, int yr, int wd);
        jjy_req_t r;
        r.command = cmd;
        r.minute = 6'(mi);
        r.hour = 5'(hr);
        r.day_of_year = 9'(dy);
        r.year_two_digit = 7'(yr);
        r.weekday = 3'(wd);
        return r;
    endfunction

    function automatic jjy_res_t mk_res(logic pin, int sec, jjy_pkg::sym_t sym, logic fend,
                                        logic busy, logic acc);
        jjy_res_t o;
        o.pin = pin;
        o.sec = 6'(sec);
        o.sym = sym;
        o.fend = fend;
        o.busy = busy;
        o.acc = acc;
        return o;
    endfunction

    function automatic jjy_req_t random_start();
        if ($urandom_range(0, 3) == 0)
            return mk_req(CMD_START, $urandom_range(0, 63), $urandom_range(0, 31),
                          $urandom_range(0, 511), $urandom_range(0, 127), $urandom_range(0, 7));
        return mk_req(CMD_START, $urandom_range(0, 59), $urandom_range(0, 23),
                      $urandom_range(1, 366), $urandom_range(0, 99), $urandom_range(0, 6));
    endfunction

    // The time fields are don't-care on a tick, so they carry noise.
    function automatic jjy_req_t random_tick();
        return mk_req(CMD_TICK, $urandom_range(0, 63), $urandom_range(0, 31),
                      $urandom_range(0, 511), $urandom_range(0, 127), $urandom_range(0, 7));
    endfunction

    function automatic int pick_gap(int mode);
        int r;
        r = $urandom_range(0, 99);
        if (mode == 0 || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [jjy_pkg::CFG_W-1:0] pick_tps();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8)
            return jjy_pkg::CFG_W'($urandom_range(0, 1));
        if (r < 80)
            return jjy_pkg::CFG_W'($urandom_range(2, 6));
        if (r < 90)
            return jjy_pkg::CFG_W'($urandom_range(7, 24));
        if (r < 95)
            return jjy_pkg::CFG_W'(4095);
        return jjy_pkg::CFG_W'(1000);
    endfunction

    function automatic logic [jjy_pkg::CFG_W-1:0] pick_low(logic [jjy_pkg::CFG_W-1:0] tps);
        int r;
        r = $urandom_range(0, 99);
        if (r < 12)
            return '0;
        if (r < 75)
            return jjy_pkg::CFG_W'($urandom_range(0, int'(tps) + 1));
        if (r < 85)
            return jjy_pkg::CFG_W'(4095);
        return jjy_pkg::CFG_W'($urandom_range(0, 4095));
    endfunction

    task automatic check_field(string name, int want, int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            n_errors++;
        end
    endtask

    task automatic idle_sender(int cycles);
        if (cycles > 0) begin
            s_valid <= 1'b0;
            repeat (cycles) @(posedge aclk);
        end
    endtask

    task automatic offer_request(jjy_req_t r, bit typed, jjy_res_t typed_res);
        jjy_res_t predicted;
        s_valid <= 1'b1;
        s_command <= r.command;
        s_minute <= r.minute;
        s_hour <= r.hour;
        s_day_of_year <= r.day_of_year;
        s_year_two_digit <= r.year_two_digit;
        s_weekday <= r.weekday;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predicted = advance_jjy(r);
        expected_line.push_back(typed ? typed_res : predicted);
        n_sent++;
    endtask

    // Registers change only with no request in flight.
    task automatic write_reg(jjy_pkg::cfg_reg_t sel, logic [jjy_pkg::CFG_W-1:0] v);
        s_valid <= 1'b0;
        while (expected_line.size() != 0) @(posedge aclk);
        repeat (2) @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_addr <= sel;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_we <= 1'b0;
        case (sel)
            jjy_pkg::REG_TICKS_PER_SECOND: tps_reg = v;
            jjy_pkg::REG_MARKER_LOW:       marker_reg = v;
            jjy_pkg::REG_ONE_LOW:          one_reg = v;
            default:                       zero_reg = v;
        endcase
        n_cfg_writes++;
    endtask

    task automatic row_cfg(jjy_pkg::cfg_reg_t sel, int v);
        stim_row_t row;
        row = '{kind: ROW_CFG, sel: sel, value: jjy_pkg::CFG_W'(v), reps: 1, req: '0,
                typed: 1'b0, res: '0};
        dir_rows.push_back(row);
    endtask

    task automatic row_req(jjy_req_t r, int reps);
        stim_row_t row;
        row = '{kind: ROW_REQ, sel: jjy_pkg::REG_TICKS_PER_SECOND, value: '0, reps: reps,
                req: r, typed: 1'b0, res: '0};
        dir_rows.push_back(row);
    endtask

    task automatic row_typed(jjy_req_t r, jjy_res_t res);
        stim_row_t row;
        row = '{kind: ROW_REQ, sel: jjy_pkg::REG_TICKS_PER_SECOND, value: '0, reps: 1,
                req: r, typed: 1'b1, res: res};
        dir_rows.push_back(row);
    endtask

    always @(posedge aclk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    always @(posedge aclk) begin : result_check
        jjy_res_t want;
        if (aresetn && m_valid && m_ready) begin
            n_results++;
            if (expected_line.size() == 0) begin
                $error("result arrived with no request outstanding");
                n_errors++;
            end else begin
                want = expected_line.pop_front();
                check_field("pin_level", int'(want.pin), int'(m_pin_level));
                check_field("second_index", int'(want.sec), int'(m_second_index));
                check_field("symbol", int'(want.sym), int'(m_symbol));
                check_field("frame_end", int'(want.fend), int'(m_frame_end));
                check_field("busy_res", int'(want.busy), int'(m_busy_res));
                check_field("start_accepted", int'(want.acc), int'(m_start_accepted));
            end
        end
    end

    initial begin : result_ready
        int r;
        do @(posedge aclk); while (!aresetn);
        forever begin
            if (!held_off && n_results >= HOLD_OFF_AFTER) begin
                // Long hold-off so the output register fills and the input stalls.
                m_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge aclk);
                held_off = 1'b1;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 60) begin
                    m_ready <= 1'b1;
                    repeat ($urandom_range(1, 24)) @(posedge aclk);
                end else if (r < 94) begin
                    m_ready <= 1'b0;
                    repeat ($urandom_range(1, 3)) @(posedge aclk);
                end else begin
                    m_ready <= 1'b0;
                    repeat ($urandom_range(10, 40)) @(posedge aclk);
                end
            end
        end
    end

    initial begin : stimulus
        jjy_req_t                  req;
        jjy_req_t                  tick0;
        jjy_res_t                  idle_res;
        logic [jjy_pkg::CFG_W-1:0] tps;
        int                        r;
        int                        n_phase;
        int                        gap_mode;
        int                        n_counted;
        bit                        counted;

        aresetn = 1'b0;
        cfg_we = 1'b0;
        cfg_addr = '0;
        cfg_wdata = '0;
        s_valid = 1'b0;
        s_command = 1'b0;
        s_minute = '0;
        s_hour = '0;
        s_day_of_year = '0;
        s_year_two_digit = '0;
        s_weekday = '0;
        m_ready = 1'b0;

        tps_reg = jjy_pkg::TPS_RESET;
        marker_reg = jjy_pkg::MARKER_RESET;
        one_reg = jjy_pkg::ONE_RESET;
        zero_reg = jjy_pkg::ZERO_RESET;
        frame_bits = '0;
        sec_ctr = 0;
        tick_ctr = 0;
        sending = 1'b0;
        n_counted = 0;

        tick0 = mk_req(CMD_TICK, 0, 0, 0, 0, 0);
        idle_res = mk_res(1'b1, 0, jjy_pkg::SYM_ZERO, 1'b0, 1'b0, 1'b0);

        // Idle tick, starts at both ends of the fields, start while busy, then
        // short seconds, saturated and zero-length pulses, and a second that
        // ends early because the second length shrank under the tick counter.
        row_typed(tick0, idle_res);
        row_typed(mk_req(CMD_START, 0, 0, 0, 0, 0),
                  mk_res(1'b1, 0, jjy_pkg::SYM_MARK, 1'b0, 1'b1, 1'b1));
        row_typed(mk_req(CMD_START, 63, 31, 511, 127, 7),
                  mk_res(1'b1, 0, jjy_pkg::SYM_MARK, 1'b0, 1'b1, 1'b0));
        row_req(tick0, 3);
        row_cfg(jjy_pkg::REG_TICKS_PER_SECOND, 0);
        row_req(tick0, 60);
        row_typed(tick0, idle_res);
        row_cfg(jjy_pkg::REG_TICKS_PER_SECOND, 3);
        row_cfg(jjy_pkg::REG_MARKER_LOW, 0);
        row_cfg(jjy_pkg::REG_ONE_LOW, 4095);
        row_cfg(jjy_pkg::REG_ZERO_LOW, 1);
        row_typed(mk_req(CMD_START, 63, 31, 511, 127, 7),
                  mk_res(1'b1, 0, jjy_pkg::SYM_MARK, 1'b0, 1'b1, 1'b1));
        row_req(tick0, 180);
        row_cfg(jjy_pkg::REG_TICKS_PER_SECOND, 1);
        row_cfg(jjy_pkg::REG_MARKER_LOW, 4095);
        row_cfg(jjy_pkg::REG_ONE_LOW, 0);
        row_cfg(jjy_pkg::REG_ZERO_LOW, 4095);
        row_typed(mk_req(CMD_START, 59, 23, 366, 99, 6),
                  mk_res(1'b1, 0, jjy_pkg::SYM_MARK, 1'b0, 1'b1, 1'b1));
        row_req(tick0, 60);
        row_cfg(jjy_pkg::REG_TICKS_PER_SECOND, 4095);
        row_cfg(jjy_pkg::REG_MARKER_LOW, 2);
        row_cfg(jjy_pkg::REG_ONE_LOW, 4094);
        row_typed(mk_req(CMD_START, 37, 18, 245, 26, 3),
                  mk_res(1'b1, 0, jjy_pkg::SYM_MARK, 1'b0, 1'b1, 1'b1));
        row_req(tick0, 8);
        row_cfg(jjy_pkg::REG_TICKS_PER_SECOND, 2);
        row_req(tick0, 120);

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_rows[i]) begin
            if (dir_rows[i].kind == ROW_CFG) begin
                write_reg(dir_rows[i].sel, dir_rows[i].value);
            end else begin
                repeat (dir_rows[i].reps) begin
                    idle_sender(pick_gap(1));
                    offer_request(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].res);
                end
            end
        end

        // Random phases: mostly complete frames, with noise ticks while idle and
        // the odd start while busy.
        while (n_counted < RANDOM_REQS) begin
            tps = pick_tps();
            write_reg(jjy_pkg::REG_TICKS_PER_SECOND, tps);
            write_reg(jjy_pkg::REG_MARKER_LOW, pick_low(tps));
            write_reg(jjy_pkg::REG_ONE_LOW, pick_low(tps));
            write_reg(jjy_pkg::REG_ZERO_LOW, pick_low(tps));
            gap_mode = ($urandom_range(0, 3) == 0) ? 0 : 1;
            n_phase = (tps > 100) ? $urandom_range(5, 20) : $urandom_range(20, 60);
            repeat (n_phase) begin
                r = $urandom_range(0, 99);
                if (!sending)
                    req = (r < 85) ? random_start() : random_tick();
                else
                    req = (r < 4) ? random_start() : random_tick();
                counted = (req.command == CMD_START) ? !sending : sending;
                idle_sender(pick_gap(gap_mode));
                offer_request(req, 1'b0, '0);
                if (counted)
                    n_counted++;
            end
        end

        s_valid <= 1'b0;
        while (expected_line.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);

        $display("Run covered %0d requests and %0d register writes over several settings.",
                 n_sent, n_cfg_writes);
        $display("Frames started: %0d, frames sent through second 59: %0d.",
                 frames_started, frames_done);
        if (n_errors == 0 && expected_line.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

[jjy_time_code_transmitter.f]
design/jjy_pkg.sv
design/jjy_cell.sv
design/jjy_enc.sv
design/jjy_time_code_transmitter.sv
dv/testbench.sv
